FILE: hw/rtl/tst_pkg.sv
// Shared types and codes for the timed slot table.
`default_nettype none
package tst_pkg;

    localparam int KEY_W      = 16;
    localparam int VAL_W      = 64;
    localparam int TIME_W     = 32;
    localparam int MAX_EVENTS = 16;
    localparam int EVCNT_W    = 5;

    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_SWEEP = 2'd2;

    localparam logic [2:0] RES_CREATED  = 3'd0;
    localparam logic [2:0] RES_UPDATED  = 3'd1;
    localparam logic [2:0] RES_DELETED  = 3'd2;
    localparam logic [2:0] RES_QUERY    = 3'd3;
    localparam logic [2:0] RES_REJECTED = 3'd4;
    localparam logic [2:0] RES_DONE     = 3'd5;

    typedef struct packed {
        logic [1:0]              kind;
        logic [KEY_W-1:0]        slot_key;
        logic signed [VAL_W-1:0] value;
        logic [TIME_W-1:0]       deadline;
        logic                    timeout_flag;
        logic                    lock_flag;
        logic [TIME_W-1:0]       current_time;
    } t_in;

    typedef struct packed {
        logic [2:0]              event_res;
        logic [KEY_W-1:0]        event_slot;
        logic signed [VAL_W-1:0] event_value;
        logic                    found;
        logic                    last;
    } t_out;

    typedef struct packed {
        logic                    valid;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        logic [TIME_W-1:0]       deadline;
        logic                    timed;
    } t_entry;

    typedef struct packed {
        logic                    set_valid;
        logic                    clr_valid;
        logic                    wr_key;
        logic                    wr_value;
        logic                    wr_deadline;
        logic                    wr_timed;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
        logic [TIME_W-1:0]       deadline;
        logic                    timed;
    } t_wr;

endpackage
`default_nettype wire

FILE: hw/rtl/timed_slot_table_core.sv
// Top level of the timed slot table: sequencer, output register and submodules.
// Each transaction scans all CAPACITY slots through one shared compare unit, one slot
// per cycle behind the storage read register. The result of a set or query is loaded
// into the output register once the scan has drained, and the core accepts again in
// the cycle after that load. An expire sweep rescans once per deleted slot, at most
// sixteen deletions per sweep. A stalled output register holds the sequencer until the
// waiting result is taken. A new transaction is taken only when the sequencer is idle;
// the final result may still sit in the output register then.
`default_nettype none
module timed_slot_table_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tst_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output tst_pkg::t_out      o_out_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    tst_pkg::t_in               r_item;
    logic [IW-1:0]              r_addr;
    logic                       r_issue;
    logic [tst_pkg::EVCNT_W-1:0] r_n;
    logic                       r_out_valid;
    tst_pkg::t_out              r_out, n_out;

    logic                       w_accept;
    logic                       w_start;
    logic                       w_load;
    logic                       w_done;
    logic                       w_last_del;
    logic                       w_out_free;
    logic [IW-1:0]              w_wr_addr;
    tst_pkg::t_wr               w_wr;

    logic                       rd_vld;
    logic [IW-1:0]              rd_idx;
    tst_pkg::t_entry            rd_ent;

    logic                       sc_match, sc_free, sc_best;
    logic [IW-1:0]              sc_match_idx, sc_free_idx, sc_best_idx;
    logic signed [tst_pkg::VAL_W-1:0] sc_match_val, sc_best_val;
    logic [tst_pkg::KEY_W-1:0]  sc_best_key;
    logic [CW-1:0]              sc_cnt;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_del  = (sc_cnt == CW'(1)) ||
                         (r_n == tst_pkg::EVCNT_W'(tst_pkg::MAX_EVENTS - 1));

    tst_store #(.CAPACITY(CAPACITY), .IW(IW)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_issue),
        .i_rd_addr (r_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr      (w_wr),
        .o_rd_vld  (rd_vld),
        .o_rd_idx  (rd_idx),
        .o_rd      (rd_ent)
    );

    tst_scan #(.IW(IW), .CW(CW)) u_scan (
        .i_clk       (i_clk),
        .i_clear     (w_start),
        .i_vld       (rd_vld),
        .i_idx       (rd_idx),
        .i_ent       (rd_ent),
        .i_key       (r_item.slot_key),
        .i_now       (r_item.current_time),
        .o_match     (sc_match),
        .o_match_idx (sc_match_idx),
        .o_match_val (sc_match_val),
        .o_free      (sc_free),
        .o_free_idx  (sc_free_idx),
        .o_best      (sc_best),
        .o_best_idx  (sc_best_idx),
        .o_best_key  (sc_best_key),
        .o_best_val  (sc_best_val),
        .o_exp_cnt   (sc_cnt)
    );

    always_comb begin
        n_state   = r_state;
        w_start   = 1'b0;
        w_load    = 1'b0;
        w_done    = 1'b1;
        w_wr      = '0;
        w_wr_addr = sc_match_idx;
        n_out     = '0;
        n_out.event_slot  = r_item.slot_key;
        n_out.event_value = r_item.value;
        n_out.last        = 1'b1;
        w_wr.key      = r_item.slot_key;
        w_wr.value    = r_item.value;
        w_wr.deadline = r_item.deadline;
        w_wr.timed    = r_item.timeout_flag && !r_item.lock_flag;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in_data.kind == tst_pkg::KIND_SET ||
                                 i_in_data.kind == tst_pkg::KIND_QUERY ||
                                 i_in_data.kind == tst_pkg::KIND_SWEEP)) begin
                    w_start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_issue && !rd_vld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    case (r_item.kind)
                        tst_pkg::KIND_SET: begin
                            if (sc_match) begin
                                n_out.event_res  = tst_pkg::RES_UPDATED;
                                w_wr.wr_deadline = 1'b1;
                                w_wr.wr_value    = !r_item.lock_flag;
                                w_wr.wr_timed    = !r_item.lock_flag;
                            end else if (sc_free) begin
                                n_out.event_res  = tst_pkg::RES_CREATED;
                                w_wr_addr        = sc_free_idx;
                                w_wr.set_valid   = 1'b1;
                                w_wr.wr_key      = 1'b1;
                                w_wr.wr_value    = 1'b1;
                                w_wr.wr_deadline = 1'b1;
                                w_wr.wr_timed    = 1'b1;
                            end else begin
                                n_out.event_res  = tst_pkg::RES_REJECTED;
                            end
                        end
                        tst_pkg::KIND_QUERY: begin
                            n_out.event_res   = tst_pkg::RES_QUERY;
                            n_out.found       = sc_match;
                            n_out.event_value = sc_match ? sc_match_val : '0;
                        end
                        default: begin
                            if (sc_best) begin
                                n_out.event_res   = tst_pkg::RES_DELETED;
                                n_out.event_slot  = sc_best_key;
                                n_out.event_value = sc_best_val;
                                n_out.last        = w_last_del;
                                w_wr_addr         = sc_best_idx;
                                w_wr.clr_valid    = 1'b1;
                                w_done            = w_last_del;
                                if (!w_last_del) begin
                                    w_start = 1'b1;
                                    n_state = S_SCAN;
                                end
                            end else begin
                                n_out.event_res   = tst_pkg::RES_DONE;
                                n_out.event_slot  = '0;
                                n_out.event_value = '0;
                            end
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_addr      <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_issue <= 1'b1;
                r_addr  <= '0;
            end else if (r_issue) begin
                if (r_addr == IW'(CAPACITY - 1)) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (w_accept) begin
                r_n <= '0;
            end else if (w_load && r_item.kind == tst_pkg::KIND_SWEEP && sc_best) begin
                r_n <= r_n + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= tst_pkg::EVCNT_W'(tst_pkg::MAX_EVENTS))
        else $error("sweep deleted more slots than allowed");

    a_done_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_item.kind == tst_pkg::KIND_SWEEP && !sc_best) |-> (r_n == '0))
        else $error("sweep done notice after a deletion");

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == S_SCAN && r_issue && r_addr == '0))
        else $error("scan did not start from the first slot");

    a_decide_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (!r_issue && !rd_vld))
        else $error("decision taken while scan still running");

    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (n_out.last == w_done))
        else $error("last flag disagrees with sequencer");

endmodule
`default_nettype wire

FILE: hw/rtl/tst_store.sv
// Slot storage: valid flags in flops, entry fields in memories with registered read.
`default_nettype none
module tst_store #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [IW-1:0]   i_rd_addr,
    input  wire logic [IW-1:0]   i_wr_addr,
    input  wire tst_pkg::t_wr    i_wr,
    output logic                 o_rd_vld,
    output logic [IW-1:0]        o_rd_idx,
    output tst_pkg::t_entry      o_rd
);

    logic [CAPACITY-1:0]                      r_valid;
    logic [tst_pkg::KEY_W-1:0]               r_key_mem   [CAPACITY];
    logic signed [tst_pkg::VAL_W-1:0]        r_val_mem   [CAPACITY];
    logic [tst_pkg::TIME_W-1:0]              r_dl_mem    [CAPACITY];
    logic                                    r_timed_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            o_rd_vld <= 1'b0;
        end else begin
            o_rd_vld <= i_rd_en;
            if (i_wr.set_valid) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_wr.clr_valid) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_key)      r_key_mem[i_wr_addr]   <= i_wr.key;
        if (i_wr.wr_value)    r_val_mem[i_wr_addr]   <= i_wr.value;
        if (i_wr.wr_deadline) r_dl_mem[i_wr_addr]    <= i_wr.deadline;
        if (i_wr.wr_timed)    r_timed_mem[i_wr_addr] <= i_wr.timed;
        if (i_rd_en) begin
            o_rd_idx    <= i_rd_addr;
            o_rd.valid  <= r_valid[i_rd_addr];
            o_rd.key    <= r_key_mem[i_rd_addr];
            o_rd.value  <= r_val_mem[i_rd_addr];
            o_rd.deadline <= r_dl_mem[i_rd_addr];
            o_rd.timed  <= r_timed_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tst_scan.sv
// Shared compare unit: folds one entry per cycle into match, free and min expired key.
`default_nettype none
module tst_scan #(
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_clear,
    input  wire logic                       i_vld,
    input  wire logic [IW-1:0]              i_idx,
    input  wire tst_pkg::t_entry            i_ent,
    input  wire logic [tst_pkg::KEY_W-1:0]  i_key,
    input  wire logic [tst_pkg::TIME_W-1:0] i_now,
    output logic                            o_match,
    output logic [IW-1:0]                   o_match_idx,
    output logic signed [tst_pkg::VAL_W-1:0] o_match_val,
    output logic                            o_free,
    output logic [IW-1:0]                   o_free_idx,
    output logic                            o_best,
    output logic [IW-1:0]                   o_best_idx,
    output logic [tst_pkg::KEY_W-1:0]       o_best_key,
    output logic signed [tst_pkg::VAL_W-1:0] o_best_val,
    output logic [CW-1:0]                   o_exp_cnt
);

    logic w_hit;
    logic w_exp;

    assign w_hit = i_ent.valid && (i_ent.key == i_key);
    assign w_exp = i_ent.valid && i_ent.timed && (i_ent.deadline != '0)
                   && (i_ent.deadline < i_now);

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            o_match   <= 1'b0;
            o_free    <= 1'b0;
            o_best    <= 1'b0;
            o_exp_cnt <= '0;
        end else if (i_vld) begin
            if (w_hit && !o_match) begin
                o_match     <= 1'b1;
                o_match_idx <= i_idx;
                o_match_val <= i_ent.value;
            end
            if (!i_ent.valid && !o_free) begin
                o_free     <= 1'b1;
                o_free_idx <= i_idx;
            end
            if (w_exp) begin
                o_exp_cnt <= o_exp_cnt + 1'b1;
                if (!o_best || (i_ent.key < o_best_key)) begin
                    o_best     <= 1'b1;
                    o_best_idx <= i_idx;
                    o_best_key <= i_ent.key;
                    o_best_val <= i_ent.value;
                end
            end
        end
    end

endmodule
`default_nettype wire
